FILE: hdl/acld_pkg.sv
// acld_pkg: types, command codes and keyword table of the ascii command line decoder
// no dependencies; used by the top level and the testbench
`default_nettype none

package acld_pkg;

    localparam int BUF_BYTES_DEF = 32;

    localparam logic [7:0] SERVO_COUNT = 8'd6;
    localparam logic [7:0] SLOT_LIMIT  = 8'd10;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_FOLD  = 8'h20;

    typedef enum logic [3:0] {
        CMD_MOVE     = 4'd0,
        CMD_SAVE     = 4'd1,
        CMD_PLAY     = 4'd2,
        CMD_ERASE    = 4'd3,
        CMD_NEUTRAL  = 4'd4,
        CMD_BLINK    = 4'd5,
        CMD_STATUS   = 4'd6,
        CMD_MOVE_ERR = 4'd7,
        CMD_SAVE_ERR = 4'd8,
        CMD_UNKNOWN  = 4'd9
    } cmd_code_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_NUM,
        PH_SPACE
    } phase_t;

    typedef enum logic [1:0] {
        NT_SERVO,
        NT_SLOT,
        NT_ANGLE
    } num_target_t;

    localparam int KW_COUNT = 7;
    localparam int KW_SCAN  = 10;

    localparam int KW_MOVE    = 0;
    localparam int KW_SAVE    = 1;
    localparam int KW_PLAY    = 2;
    localparam int KW_ERASE   = 3;
    localparam int KW_NEUTRAL = 4;
    localparam int KW_BLINK   = 5;
    localparam int KW_STATUS  = 6;

    localparam int MOVE_ARG_POS = 6;
    localparam int SAVE_ARG_POS = 7;

    // keywords left justified, zero padded
    localparam logic [8*KW_SCAN-1:0] KW_TEXT [KW_COUNT] = '{
        {"MOVER",      40'h0},
        {"GRABAR",     32'h0},
        {"REPRODUCIR"       },
        {"BORRAR",     32'h0},
        {"NEUTRO",     32'h0},
        {"PARPADEO",   16'h0},
        {"ESTADO",     32'h0}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd6, 4'd10, 4'd6, 4'd6, 4'd8, 4'd6
    };

    function automatic logic [7:0] kw_char(input int k, input logic [3:0] i);
        logic [6:0] base;
        base = 7'(8 * (KW_SCAN - 1 - int'(i)));
        return KW_TEXT[k][base +: 8];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/acld_if.sv
// acld_rx_if, acld_cmd_if: valid/ready channels for received bytes and decoded commands
// depends on nothing beyond the language
`default_nettype none

interface acld_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface acld_cmd_if;
    logic       valid;
    logic       ready;
    logic [3:0] command_code;
    logic [2:0] servo_index;
    logic [7:0] target_angle;
    logic [3:0] slot_number;

    modport source (output valid, output command_code, output servo_index,
                    output target_angle, output slot_number, input ready);
    modport sink   (input valid, input command_code, input servo_index,
                    input target_angle, input slot_number, output ready);
endinterface

`default_nettype wire

FILE: hdl/ascii_command_line_decoder_unit.sv
// ascii_command_line_decoder_unit: collects a text line in a ram and decodes it into a command
// depends on acld_pkg, acld_if.sv (acld_rx_if, acld_cmd_if) and acld_ram
//
// rx carries one received byte per word; cmd carries one decoded command per word.
// while idle, rx is ready every cycle and a byte is stored, upper-cased;
// bytes past BUF_BYTES-1 are dropped. cr or lf on a non-empty line starts a decode,
// and rx stays not ready until the command is loaded into the output register.
// the decode walks the line store through its single read port, a fetch then an exec state per byte:
// first the keyword compare over KW_SCAN positions, then the argument scans of move or save,
// and last the load of the result into the output register.
// a terminator on an empty line gives no word.
// a result waits in the output register while cmd is stalled; new bytes are still taken,
// but the next decode holds its result until the register is free.
// reset empties the line and drops any pending result; the ram is not cleared,
// as only bytes written since the last terminator are ever read.
`default_nettype none

module ascii_command_line_decoder_unit
    import acld_pkg::*;
#(
    parameter int BUF_BYTES = BUF_BYTES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    acld_rx_if.sink     rx,
    acld_cmd_if.source  cmd
);

    localparam int ADDR_W = $clog2(BUF_BYTES);

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    num_target_t       num_tgt_reg, num_tgt_next;
    logic [ADDR_W-1:0] line_len_reg, line_len_next;
    logic [ADDR_W-1:0] text_len_reg, text_len_next;
    logic              zero_seen_reg, zero_seen_next;
    logic              out_valid_reg, out_valid_next;

    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [KW_COUNT-1:0] match_reg, match_next;
    logic [7:0]          num_val_reg, num_val_next;
    logic                num_neg_reg, num_neg_next;
    logic                num_dig_reg, num_dig_next;
    logic [7:0]          servo_val_reg, servo_val_next;
    cmd_code_t           res_code_reg, res_code_next;
    logic [2:0]          res_servo_reg, res_servo_next;
    logic [7:0]          res_angle_reg, res_angle_next;
    logic [3:0]          res_slot_reg, res_slot_next;
    cmd_code_t           out_code_reg, out_code_next;
    logic [2:0]          out_servo_reg, out_servo_next;
    logic [7:0]          out_angle_reg, out_angle_next;
    logic [3:0]          out_slot_reg, out_slot_next;

    logic              wr_en;
    logic [7:0]        wr_data;
    logic [7:0]        rd_data;
    logic              in_fire;
    logic              is_term;
    logic              start_dec;
    logic              out_free;
    logic [7:0]        cur;
    logic              cur_white;
    logic              cur_digit;
    logic              cur_sign;
    logic [7:0]        cur_digit_val;
    logic              num_finish;
    logic [7:0]        num_value;
    logic              prefix_last;
    logic [KW_COUNT-1:0] match_upd;
    logic              dec_done;

    acld_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (line_len_reg),
        .wr_data (wr_data),
        .rd_addr (pos_reg),
        .rd_data (rd_data)
    );

    assign in_fire   = rx.valid && rx.ready;
    assign is_term   = (rx.rx_byte == CHAR_LF) || (rx.rx_byte == CHAR_CR);
    assign start_dec = in_fire && is_term && (line_len_reg != '0);
    assign out_free  = !out_valid_reg || cmd.ready;
    assign wr_en     = in_fire && !is_term && (line_len_reg < ADDR_W'(BUF_BYTES - 1));
    assign wr_data   = ((rx.rx_byte >= CHAR_LOW_A) && (rx.rx_byte <= CHAR_LOW_Z))
                       ? (rx.rx_byte - CASE_FOLD) : rx.rx_byte;

    // byte at the scan position, zero at and past the end of the text
    assign cur           = (pos_reg < text_len_reg) ? rd_data : 8'h00;
    assign cur_white     = (cur == CHAR_SPACE) || ((cur >= CHAR_TAB) && (cur <= CHAR_CR));
    assign cur_digit     = (cur >= CHAR_ZERO) && (cur <= CHAR_NINE);
    assign cur_sign      = (cur == CHAR_PLUS) || (cur == CHAR_MINUS);
    assign cur_digit_val = cur - CHAR_ZERO;
    assign num_finish    = !cur_digit && (num_dig_reg || !(cur_white || cur_sign));
    assign num_value     = num_neg_reg ? (8'h00 - num_val_reg) : num_val_reg;
    assign prefix_last   = (pos_reg == ADDR_W'(KW_SCAN - 1));

    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            match_upd[k] = match_reg[k];
            if ((pos_reg < ADDR_W'(KW_LEN[k])) && (cur != kw_char(k, pos_reg[3:0])))
            begin
                match_upd[k] = 1'b0;
            end
        end
    end

    always_comb
    begin
        dec_done = 1'b0;
        case (phase_reg)
            PH_PREFIX: dec_done = prefix_last && !match_upd[KW_MOVE] && !match_upd[KW_SAVE];
            PH_NUM:    dec_done = num_finish && (num_tgt_reg != NT_SERVO);
            PH_SPACE:  dec_done = (cur == 8'h00)
                                  || ((cur == CHAR_SPACE) && (servo_val_reg >= SERVO_COUNT));
            default:   dec_done = 1'b1;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start_dec) state_next = S_FETCH;
            S_FETCH: state_next = S_EXEC;
            S_EXEC:  state_next = dec_done ? S_DONE : S_FETCH;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        phase_next     = phase_reg;
        num_tgt_next   = num_tgt_reg;
        line_len_next  = line_len_reg;
        text_len_next  = text_len_reg;
        zero_seen_next = zero_seen_reg;
        out_valid_next = out_valid_reg;
        pos_next       = pos_reg;
        match_next     = match_reg;
        num_val_next   = num_val_reg;
        num_neg_next   = num_neg_reg;
        num_dig_next   = num_dig_reg;
        servo_val_next = servo_val_reg;
        res_code_next  = res_code_reg;
        res_servo_next = res_servo_reg;
        res_angle_next = res_angle_reg;
        res_slot_next  = res_slot_reg;
        out_code_next  = out_code_reg;
        out_servo_next = out_servo_reg;
        out_angle_next = out_angle_reg;
        out_slot_next  = out_slot_reg;

        if (out_valid_reg && cmd.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (wr_en)
                begin
                    line_len_next = line_len_reg + 1'b1;
                    if (wr_data == 8'h00)
                    begin
                        zero_seen_next = 1'b1;
                    end
                    else if (!zero_seen_reg)
                    begin
                        text_len_next = text_len_reg + 1'b1;
                    end
                end
                if (start_dec)
                begin
                    pos_next       = '0;
                    match_next     = '1;
                    phase_next     = PH_PREFIX;
                    res_code_next  = CMD_UNKNOWN;
                    res_servo_next = '0;
                    res_angle_next = '0;
                    res_slot_next  = '0;
                end
            end
            S_EXEC:
            begin
                case (phase_reg)
                    PH_PREFIX:
                    begin
                        match_next = match_upd;
                        if (!prefix_last)
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                        else
                        begin
                            num_val_next = '0;
                            num_neg_next = 1'b0;
                            num_dig_next = 1'b0;
                            if (match_upd[KW_MOVE])
                            begin
                                pos_next     = ADDR_W'(MOVE_ARG_POS);
                                phase_next   = PH_NUM;
                                num_tgt_next = NT_SERVO;
                            end
                            else if (match_upd[KW_SAVE])
                            begin
                                pos_next     = ADDR_W'(SAVE_ARG_POS);
                                phase_next   = PH_NUM;
                                num_tgt_next = NT_SLOT;
                            end
                            else if (match_upd[KW_PLAY])    res_code_next = CMD_PLAY;
                            else if (match_upd[KW_ERASE])   res_code_next = CMD_ERASE;
                            else if (match_upd[KW_NEUTRAL]) res_code_next = CMD_NEUTRAL;
                            else if (match_upd[KW_BLINK])   res_code_next = CMD_BLINK;
                            else if (match_upd[KW_STATUS])  res_code_next = CMD_STATUS;
                            else                            res_code_next = CMD_UNKNOWN;
                        end
                    end
                    PH_NUM:
                    begin
                        if (num_finish)
                        begin
                            case (num_tgt_reg)
                                NT_SERVO:
                                begin
                                    servo_val_next = num_value;
                                    pos_next       = ADDR_W'(MOVE_ARG_POS);
                                    phase_next     = PH_SPACE;
                                end
                                NT_SLOT:
                                begin
                                    if (num_value < SLOT_LIMIT)
                                    begin
                                        res_code_next = CMD_SAVE;
                                        res_slot_next = num_value[3:0];
                                    end
                                    else
                                    begin
                                        res_code_next = CMD_SAVE_ERR;
                                    end
                                end
                                default:
                                begin
                                    res_code_next  = CMD_MOVE;
                                    res_servo_next = servo_val_reg[2:0];
                                    res_angle_next = num_value;
                                end
                            endcase
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                            if (cur_digit)
                            begin
                                num_val_next = (num_val_reg << 3) + (num_val_reg << 1)
                                               + cur_digit_val;
                                num_dig_next = 1'b1;
                            end
                            else if (cur_sign)
                            begin
                                num_neg_next = (cur == CHAR_MINUS);
                                num_dig_next = 1'b1;
                            end
                        end
                    end
                    PH_SPACE:
                    begin
                        if (cur == 8'h00)
                        begin
                            res_code_next = CMD_MOVE_ERR;
                        end
                        else if (cur == CHAR_SPACE)
                        begin
                            if (servo_val_reg < SERVO_COUNT)
                            begin
                                pos_next     = pos_reg + 1'b1;
                                phase_next   = PH_NUM;
                                num_tgt_next = NT_ANGLE;
                                num_val_next = '0;
                                num_neg_next = 1'b0;
                                num_dig_next = 1'b0;
                            end
                            else
                            begin
                                res_code_next = CMD_MOVE_ERR;
                            end
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        res_code_next = CMD_UNKNOWN;
                    end
                endcase
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_code_next  = res_code_reg;
                    out_servo_next = res_servo_reg;
                    out_angle_next = res_angle_reg;
                    out_slot_next  = res_slot_reg;
                    line_len_next  = '0;
                    text_len_next  = '0;
                    zero_seen_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_PREFIX;
            num_tgt_reg   <= NT_SERVO;
            line_len_reg  <= '0;
            text_len_reg  <= '0;
            zero_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            num_tgt_reg   <= num_tgt_next;
            line_len_reg  <= line_len_next;
            text_len_reg  <= text_len_next;
            zero_seen_reg <= zero_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        match_reg     <= match_next;
        num_val_reg   <= num_val_next;
        num_neg_reg   <= num_neg_next;
        num_dig_reg   <= num_dig_next;
        servo_val_reg <= servo_val_next;
        res_code_reg  <= res_code_next;
        res_servo_reg <= res_servo_next;
        res_angle_reg <= res_angle_next;
        res_slot_reg  <= res_slot_next;
        out_code_reg  <= out_code_next;
        out_servo_reg <= out_servo_next;
        out_angle_reg <= out_angle_next;
        out_slot_reg  <= out_slot_next;
    end

    assign rx.ready         = (state_reg == S_IDLE);
    assign cmd.valid        = out_valid_reg;
    assign cmd.command_code = out_code_reg;
    assign cmd.servo_index  = out_servo_reg;
    assign cmd.target_angle = out_angle_reg;
    assign cmd.slot_number  = out_slot_reg;

endmodule

`default_nettype wire

FILE: hdl/acld_ram.sv
// acld_ram: generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module acld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: dv/ascii_command_line_decoder_unit_tb.sv
// ascii_command_line_decoder_unit_tb: directed lines, then random lines, fed byte by byte
// into the decoder; every command word is checked against a typed line's listed word or
// a line-decoding model kept here; depends on acld_pkg, acld_if.sv and the decoder rtl
module ascii_command_line_decoder_unit_tb;
    import acld_pkg::*;

    localparam int LINE_BYTES = BUF_BYTES_DEF;
    localparam int ITEM_COUNT = 1900;
    localparam int LONG_HOLD = 500;
    localparam int DRAIN_CYCLES = 250;
    localparam longint TIMEOUT = 64'd40_000_000;

    typedef struct packed {
        cmd_code_t  code;
        logic [2:0] servo;
        logic [7:0] angle;
        logic [3:0] slot;
    } cmd_word_t;

    typedef struct {
        string      head;
        int         inner;
        string      tail;
        logic [7:0] term;
        bit         typed;
        cmd_word_t  want;
    } test_line_t;

    localparam cmd_word_t NO_WANT = '{CMD_UNKNOWN, 3'd0, 8'd0, 4'd0};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    acld_rx_if  rx_ch ();
    acld_cmd_if cmd_ch ();

    ascii_command_line_decoder_unit #(
        .BUF_BYTES(LINE_BYTES)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .cmd   (cmd_ch)
    );

    string      kw_words [KW_COUNT] = '{"MOVER", "GRABAR", "REPRODUCIR", "BORRAR",
                                        "NEUTRO", "PARPADEO", "ESTADO"};
    logic [7:0] line_buf [LINE_BYTES];
    int         line_len = 0;
    cmd_word_t  expected_cmds [$];
    logic [7:0] line_bytes [$];
    test_line_t test_lines [24];
    int         sent_bytes = 0;
    int         err_count = 0;
    bit         long_hold = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // line model
    function automatic logic [7:0] char_at(input int pos, input int tlen);
        return (pos < tlen) ? line_buf[pos] : 8'h00;
    endfunction

    function automatic bit kw_hit(input string kw, input int tlen);
        for (int i = 0; i < kw.len(); i++)
        begin
            if (i >= tlen || line_buf[i] != kw[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] read_arg(input int start, input int tlen);
        logic [7:0] v;
        logic [7:0] c;
        bit         neg;
        int         pos;
        pos = start;
        v = 8'd0;
        neg = 1'b0;
        c = char_at(pos, tlen);
        while (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))
        begin
            pos++;
            c = char_at(pos, tlen);
        end
        if (c == CHAR_PLUS || c == CHAR_MINUS)
        begin
            neg = (c == CHAR_MINUS);
            pos++;
            c = char_at(pos, tlen);
        end
        while (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            v = v * 8'd10 + (c - CHAR_ZERO);
            pos++;
            c = char_at(pos, tlen);
        end
        return neg ? 8'd0 - v : v;
    endfunction

    function automatic cmd_word_t decode_line();
        cmd_word_t  w;
        int         tlen;
        int         p;
        bit         found;
        logic [7:0] arg;
        w = NO_WANT;
        tlen = 0;
        while (tlen < line_len && line_buf[tlen] != 8'h00)
            tlen++;
        if (kw_hit(kw_words[KW_MOVE], tlen))
        begin
            arg = read_arg(MOVE_ARG_POS, tlen);
            found = 1'b0;
            for (p = MOVE_ARG_POS; p < tlen; p++)
            begin
                if (line_buf[p] == CHAR_SPACE)
                begin
                    found = 1'b1;
                    break;
                end
            end
            if (found && arg < SERVO_COUNT)
            begin
                w.code = CMD_MOVE;
                w.servo = arg[2:0];
                w.angle = read_arg(p + 1, tlen);
            end
            else
                w.code = CMD_MOVE_ERR;
        end
        else if (kw_hit(kw_words[KW_SAVE], tlen))
        begin
            arg = read_arg(SAVE_ARG_POS, tlen);
            if (arg < SLOT_LIMIT)
            begin
                w.code = CMD_SAVE;
                w.slot = arg[3:0];
            end
            else
                w.code = CMD_SAVE_ERR;
        end
        else if (kw_hit(kw_words[KW_PLAY], tlen))
            w.code = CMD_PLAY;
        else if (kw_hit(kw_words[KW_ERASE], tlen))
            w.code = CMD_ERASE;
        else if (kw_hit(kw_words[KW_NEUTRAL], tlen))
            w.code = CMD_NEUTRAL;
        else if (kw_hit(kw_words[KW_BLINK], tlen))
            w.code = CMD_BLINK;
        else if (kw_hit(kw_words[KW_STATUS], tlen))
            w.code = CMD_STATUS;
        return w;
    endfunction

    function automatic bit take_byte(input logic [7:0] b, output cmd_word_t w);
        logic [7:0] c;
        w = NO_WANT;
        c = b;
        if (c == CHAR_LF || c == CHAR_CR)
        begin
            if (line_len > 0)
            begin
                w = decode_line();
                line_len = 0;
                return 1'b1;
            end
            return 1'b0;
        end
        if (line_len < LINE_BYTES - 1)
        begin
            if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z)
                c = c - CASE_FOLD;
            line_buf[line_len] = c;
            line_len++;
        end
        return 1'b0;
    endfunction

    // line building
    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endtask

    task automatic push_keyword(input int k);
        logic [7:0] c;
        for (int i = 0; i < kw_words[k].len(); i++)
        begin
            c = kw_words[k][i];
            if ($urandom_range(0, 1) == 0)
                c = c + CASE_FOLD;
            line_bytes.push_back(c);
        end
    endtask

    task automatic push_number(input int hi);
        int kind;
        int v;
        int w;
        kind = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 2))
            begin
                w = $urandom_range(0, 3);
                case (w)
                    0: line_bytes.push_back(CHAR_SPACE);
                    1: line_bytes.push_back(CHAR_TAB);
                    2: line_bytes.push_back(8'h0B);
                    default: line_bytes.push_back(8'h0C);
                endcase
            end
        end
        w = $urandom_range(0, 9);
        if (w == 0)
            line_bytes.push_back(CHAR_PLUS);
        else if (w == 1)
            line_bytes.push_back(CHAR_MINUS);
        if (kind == 0)
            return;
        if (kind == 1)
            v = $urandom_range(256, 99999);
        else
            v = $urandom_range(0, hi);
        if (kind == 2)
            line_bytes.push_back(CHAR_ZERO);
        push_text($sformatf("%0d", v));
    endtask

    task automatic build_good_line();
        int k;
        k = $urandom_range(0, KW_COUNT - 1);
        push_keyword(k);
        if (k == KW_MOVE)
        begin
            line_bytes.push_back(CHAR_SPACE);
            push_number(7);
            if ($urandom_range(0, 9) != 0)
                line_bytes.push_back(CHAR_SPACE);
            push_number(255);
        end
        else if (k == KW_SAVE)
        begin
            line_bytes.push_back(CHAR_SPACE);
            push_number(12);
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            line_bytes.push_back(CHAR_SPACE);
            repeat ($urandom_range(1, 6))
                line_bytes.push_back(8'($urandom_range(8'h41, 8'h7A)));
        end
    endtask

    task automatic build_random_line();
        int kind;
        kind = $urandom_range(0, 99);
        line_bytes.delete();
        if (kind < 70)
            build_good_line();
        else if (kind < 85)
        begin
            build_good_line();
            if ($urandom_range(0, 1) == 0)
                repeat ($urandom_range(1, line_bytes.size() - 1))
                    void'(line_bytes.pop_back());
            else
                line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end
        else
        begin
            repeat ($urandom_range(0, 40))
                line_bytes.push_back(8'($urandom_range(0, 255)));
        end
        line_bytes.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        if ($urandom_range(0, 7) == 0)
            line_bytes.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
    endtask

    // byte sender
    task automatic send_word(input logic [7:0] b, input int gap, input bit typed,
                             input cmd_word_t want);
        cmd_word_t pred;
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (rx_ch.ready !== 1'b1);
        sent_bytes++;
        if (take_byte(b, pred))
            expected_cmds.push_back(typed ? want : pred);
    endtask

    task automatic send_line(input bit typed, input cmd_word_t want, input bit burst);
        int n;
        n = line_bytes.size();
        for (int i = 0; i < n; i++)
            send_word(line_bytes[i], burst ? 0 : $urandom_range(0, 14), typed && i == n - 1, want);
    endtask

    // command checker
    task automatic field_check(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            err_count++;
        end
    endtask

    task automatic check_cmd();
        cmd_word_t want;
        if (expected_cmds.size() == 0)
        begin
            $error("unexpected command word: code %0d", cmd_ch.command_code);
            err_count++;
            return;
        end
        want = expected_cmds.pop_front();
        field_check("command_code", 8'(want.code), 8'(cmd_ch.command_code));
        field_check("servo_index", 8'(want.servo), 8'(cmd_ch.servo_index));
        field_check("target_angle", want.angle, cmd_ch.target_angle);
        field_check("slot_number", 8'(want.slot), 8'(cmd_ch.slot_number));
    endtask

    initial
    begin
        int stall;
        cmd_ch.ready <= 1'b0;
        repeat (12) @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                cmd_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                stall = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 14);
                if (stall > 0)
                begin
                    cmd_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            cmd_ch.ready <= 1'b1;
            do @(posedge clk); while (cmd_ch.valid !== 1'b1);
            check_cmd();
        end
    end

    initial
    begin
        #(TIMEOUT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rx_ch.valid <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        test_lines = '{
            '{"",            -1, "",      CHAR_CR, 1'b0, NO_WANT},
            '{"MOVER 0 90",  -1, "",      CHAR_LF, 1'b1, '{CMD_MOVE, 3'd0, 8'd90, 4'd0}},
            '{"mover 5 255", -1, "",      CHAR_CR, 1'b1, '{CMD_MOVE, 3'd5, 8'd255, 4'd0}},
            '{"MOVER 6 10",  -1, "",      CHAR_CR, 1'b1, '{CMD_MOVE_ERR, 3'd0, 8'd0, 4'd0}},
            '{"MOVER 3",     -1, "",      CHAR_LF, 1'b1, '{CMD_MOVE_ERR, 3'd0, 8'd0, 4'd0}},
            '{"MOVER 2 -1",  -1, "",      CHAR_CR, 1'b1, '{CMD_MOVE, 3'd2, 8'd255, 4'd0}},
            '{"MOVER 1 +300", -1, "",     CHAR_LF, 1'b1, '{CMD_MOVE, 3'd1, 8'd44, 4'd0}},
            '{"MOVER  4 7",  -1, "",      CHAR_CR, 1'b0, NO_WANT},
            '{"MOVER 5\t7 200", -1, "",   CHAR_LF, 1'b0, NO_WANT},
            '{"MOVER 0 99999", -1, "",    CHAR_CR, 1'b0, NO_WANT},
            '{"GRABAR 0",    -1, "",      CHAR_CR, 1'b1, '{CMD_SAVE, 3'd0, 8'd0, 4'd0}},
            '{"grabar 9",    -1, "",      CHAR_LF, 1'b1, '{CMD_SAVE, 3'd0, 8'd0, 4'd9}},
            '{"GRABAR 10",   -1, "",      CHAR_CR, 1'b1, '{CMD_SAVE_ERR, 3'd0, 8'd0, 4'd0}},
            '{"GRABAR -246", -1, "",      CHAR_LF, 1'b0, NO_WANT},
            '{"GRABAR",      -1, "",      CHAR_CR, 1'b0, NO_WANT},
            '{"GRABAR \t 5", -1, "",      CHAR_CR, 1'b0, NO_WANT},
            '{"REPRODUCIR",  -1, "",      CHAR_LF, 1'b1, '{CMD_PLAY, 3'd0, 8'd0, 4'd0}},
            '{"BORRARX",     -1, "",      CHAR_CR, 1'b1, '{CMD_ERASE, 3'd0, 8'd0, 4'd0}},
            '{"neutro",      -1, "",      CHAR_LF, 1'b1, '{CMD_NEUTRAL, 3'd0, 8'd0, 4'd0}},
            '{"PARPADEO 3",  -1, "",      CHAR_CR, 1'b1, '{CMD_BLINK, 3'd0, 8'd0, 4'd0}},
            '{"MOVE",        -1, "",      CHAR_CR, 1'b1, '{CMD_UNKNOWN, 3'd0, 8'd0, 4'd0}},
            '{"MOVER 1",      0, " 9",    CHAR_LF, 1'b0, NO_WANT},
            '{"",             0, "ESTADO", CHAR_CR, 1'b0, NO_WANT},
            '{"estado xxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxx", 255, "MOVER 1 2",
              CHAR_LF, 1'b0, NO_WANT}
        };
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (test_lines[r])
        begin
            line_bytes.delete();
            push_text(test_lines[r].head);
            if (test_lines[r].inner >= 0)
                line_bytes.push_back(8'(test_lines[r].inner));
            push_text(test_lines[r].tail);
            line_bytes.push_back(test_lines[r].term);
            send_line(test_lines[r].typed, test_lines[r].want, 1'b0);
        end

        // stall the command side while short lines keep coming
        long_hold = 1'b1;
        repeat (15)
        begin
            line_bytes.delete();
            build_good_line();
            line_bytes.push_back(CHAR_CR);
            send_line(1'b0, NO_WANT, 1'b1);
        end

        while (sent_bytes < ITEM_COUNT)
        begin
            build_random_line();
            send_line(1'b0, NO_WANT, $urandom_range(0, 7) == 0);
        end
        rx_ch.valid <= 1'b0;

        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/acld_pkg.sv
hdl/acld_if.sv
hdl/acld_ram.sv
hdl/ascii_command_line_decoder_unit.sv
dv/ascii_command_line_decoder_unit_tb.sv
